[design/alpc_pkg.sv]
// Shared constants, types and helpers for the allele link phase classifier.
package alpc_pkg;

  localparam int MAX_ALLELES = 8;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_W       = 4;
  localparam int ROW_W       = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1;
  localparam int NUM_W       = ROW_W + 1;
  localparam int ADDR_W      = 2 * ROW_W;

  // register indexes on the config channel
  localparam logic [0:0] CFG_FIRST  = 1'b0;
  localparam logic [0:0] CFG_SECOND = 1'b1;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PAIR    = 2'd1,
    REQ_MISSING = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  localparam logic [2:0] PHASE_AND      = 3'd0;
  localparam logic [2:0] PHASE_REF_ALT  = 3'd1;
  localparam logic [2:0] PHASE_TO_REF   = 3'd2;
  localparam logic [2:0] PHASE_XOR      = 3'd3;
  localparam logic [2:0] PHASE_OTHER    = 3'd4;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } cell_wr_t;

  // register value clamped to 1..MAX_ALLELES
  function automatic logic [NUM_W-1:0] eff_count(input logic [CFG_W-1:0] v);
    logic [NUM_W-1:0] r;
    if (v == '0) begin
      r = NUM_W'(1);
    end else if (int'(v) > MAX_ALLELES) begin
      r = NUM_W'(MAX_ALLELES);
    end else begin
      r = NUM_W'(v);
    end
    return r;
  endfunction

endpackage

[design/allele_link_phase_classifier_unit.sv]
// Allele link phase classifier: sequencer sweeping the link counter matrix.
// Swept area per item, from accept to result (cells visited in S_RUN):
//   clear/query n1*n2, pair 1 / n1 / n2 / n1*n2, missing MAX_ALLELES^2.
//   An item with a bad index sweeps no cells and goes straight to its result.
// Throughput: one item at a time, set by the one-cell-per-cycle read-modify-write
//   on the counter store; a new word is taken while a result waits.
// Reset: counters read as zero, both allele counts 2, no result pending.
module allele_link_phase_classifier_unit
  import alpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  req_type,
  input  logic [2:0]  first_genotype,
  input  logic        first_is_wild,
  input  logic [2:0]  second_genotype,
  input  logic        second_is_wild,
  input  logic [2:0]  query_first_allele,
  input  logic [2:0]  query_second_allele,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  phase_code,
  output logic        index_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FINISH} state_t;

  state_t           state;
  req_t             op;
  logic [CFG_W-1:0] first_cfg, second_cfg;
  logic [ROW_W-1:0] row, col, row_hi, col_lo, col_hi;
  logic [ROW_W-1:0] qa1, qa2;
  logic [ROW_W-1:0] p_row, p_col;
  logic             pv;
  logic             err, to_ref, ref_row_hit, to_alt, other;

  logic [NUM_W-1:0]      n1, n2, n1_last, n2_last;
  req_t                  in_op;
  logic                  in_err;
  logic [ROW_W-1:0]      g1, g2;
  logic [COUNT_BITS-1:0] cur, inc;
  logic                  cur_pos;
  cell_wr_t              wr;
  logic [2:0]            code;

  assign n1      = eff_count(first_cfg);
  assign n2      = eff_count(second_cfg);
  assign n1_last = n1 - NUM_W'(1);
  assign n2_last = n2 - NUM_W'(1);
  assign in_op   = req_t'(req_type);
  assign g1      = ROW_W'(first_genotype);
  assign g2      = ROW_W'(second_genotype);

  always_comb begin
    unique case (in_op)
      REQ_PAIR: in_err = (!first_is_wild && int'(first_genotype) >= int'(n1)) ||
                         (!second_is_wild && int'(second_genotype) >= int'(n2));
      REQ_QUERY: in_err = (query_first_allele == '0) ||
                          (int'(query_first_allele) >= int'(n1)) ||
                          (query_second_allele == '0) ||
                          (int'(query_second_allele) >= int'(n2));
      default: in_err = 1'b0;
    endcase
  end

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  alpc_cell_store u_store (
    .clk   (clk),
    .rst   (rst),
    .raddr ({row, col}),
    .wr    (wr),
    .count (cur)
  );

  // cell stage: data for (p_row, p_col) arrives in the cycle after its read
  assign inc     = (cur == '1) ? cur : cur + COUNT_BITS'(1);
  assign cur_pos = (cur != '0);

  always_comb begin
    wr.en   = pv && (op != REQ_QUERY);
    wr.addr = {p_row, p_col};
    wr.data = (op == REQ_CLEAR) ? '0 : inc;
  end

  always_comb begin
    if (op != REQ_QUERY) begin
      code = PHASE_AND;
    end else if (err || other) begin
      code = PHASE_OTHER;
    end else if (!to_alt) begin
      code = PHASE_XOR;
    end else begin
      unique case ({ref_row_hit, to_ref})
        2'b00:   code = PHASE_AND;
        2'b10:   code = PHASE_REF_ALT;
        2'b01:   code = PHASE_TO_REF;
        default: code = PHASE_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_cfg    <= CFG_W'(2);
      second_cfg   <= CFG_W'(2);
      pv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pv <= (state == S_RUN);

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIRST:  first_cfg  <= cfg_data;
          CFG_SECOND: second_cfg <= cfg_data;
        endcase
      end

      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      // query flags from the cell stage
      if (pv && op == REQ_QUERY && cur_pos) begin
        if (p_row == qa1 && p_col == '0) to_ref <= 1'b1;
        if (p_row == '0 && p_col == qa2) ref_row_hit <= 1'b1;
        if (p_row == qa1 && p_col == qa2) to_alt <= 1'b1;
        if ((p_row == qa1 && p_col != '0 && p_col != qa2) ||
            (p_col == qa2 && p_row != '0 && p_row != qa1)) begin
          other <= 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op          <= in_op;
            err         <= in_err;
            qa1         <= ROW_W'(query_first_allele);
            qa2         <= ROW_W'(query_second_allele);
            to_ref      <= 1'b0;
            ref_row_hit <= 1'b0;
            to_alt      <= 1'b0;
            other       <= 1'b0;
            unique case (in_op)
              REQ_PAIR: begin
                row    <= first_is_wild ? '0 : g1;
                row_hi <= first_is_wild ? n1_last[ROW_W-1:0] : g1;
                col    <= second_is_wild ? '0 : g2;
                col_lo <= second_is_wild ? '0 : g2;
                col_hi <= second_is_wild ? n2_last[ROW_W-1:0] : g2;
              end
              REQ_MISSING: begin
                row    <= '0;
                row_hi <= '1;
                col    <= '0;
                col_lo <= '0;
                col_hi <= '1;
              end
              default: begin
                row    <= '0;
                row_hi <= n1_last[ROW_W-1:0];
                col    <= '0;
                col_lo <= '0;
                col_hi <= n2_last[ROW_W-1:0];
              end
            endcase
            state <= in_err ? S_FINISH : S_RUN;
          end
        end
        S_RUN: begin
          p_row <= row;
          p_col <= col;
          if (col == col_hi) begin
            col <= col_lo;
            row <= row + ROW_W'(1);
          end else begin
            col <= col + ROW_W'(1);
          end
          if (row == row_hi && col == col_hi) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            phase_code   <= code;
            index_error  <= err;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_idle_no_cell_work: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !pv && !wr.en)
    else $error("cell stage busy while idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("word accepted but block still ready");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    result_valid && index_error |-> phase_code == PHASE_OTHER || phase_code == PHASE_AND)
    else $error("bad code on index error");

endmodule

[design/alpc_cell_store.sv]
// Link counter store: one write and one registered read per cycle, valid bits for reset.
module alpc_cell_store
  import alpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ADDR_W-1:0]     raddr,
  input  cell_wr_t              wr,
  output logic [COUNT_BITS-1:0] count
);

  localparam int DEPTH = MAX_ALLELES * MAX_ALLELES;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld;
  logic [COUNT_BITS-1:0] rdata;
  logic                  rvld;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      rvld <= vld[raddr];
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
    end
  end

  // never-written cells read as zero
  assign count = rvld ? rdata : '0;

endmodule
